### rtl/hds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_pkg
// Shared widths, types and helpers for the heat diffusion stencil sweep.
// ----------------------------------------------------------------------------
package hds_pkg;

   localparam int GRID_MAX  = 256;
   localparam int TEMP_BITS = 16;
   localparam int ADDR_BITS = $clog2(GRID_MAX);
   localparam int POS_BITS  = 8;
   localparam int SIZE_BITS = 9;
   localparam int SUM_BITS  = TEMP_BITS + 2;

   localparam logic [SIZE_BITS-1:0] GRID_MIN   = SIZE_BITS'(3);
   localparam logic [SIZE_BITS-1:0] GRID_LIMIT = SIZE_BITS'(GRID_MAX);
   localparam logic [SIZE_BITS-1:0] GRID_RESET = SIZE_BITS'(200);

   typedef logic [TEMP_BITS-1:0] temp_type;
   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [SIZE_BITS-1:0] size_type;

   // accepted item and where it sits in the grid
   typedef struct packed {
      temp_type temp;
      pos_type  row;
      pos_type  col;
   } item_type;

   // line buffer write-back when an item retires
   typedef struct packed {
      logic     en;
      addr_type addr;
      temp_type prev_val;
      temp_type older_val;
   } wb_type;

   function automatic size_type clamp_size(input size_type raw);
      size_type n;
      n = raw;
      if (n < GRID_MIN)   n = GRID_MIN;
      if (n > GRID_LIMIT) n = GRID_LIMIT;
      return n;
   endfunction

endpackage

### rtl/hds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_ram
// Simple dual-port line buffer RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hds_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_core
// Stencil stage: holds one item, combines line buffer reads, sequences up to
// two results into the output register and issues the line buffer write-back.
// ----------------------------------------------------------------------------
module hds_core import hds_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     restart,     // frame restart from a size write
   input  size_type size_last,   // active size minus one
   input  logic     accept,
   input  item_type item,
   input  temp_type centre_rd,   // prev row at c
   input  temp_type right_rd,    // prev row at c+1
   input  temp_type up_rd,       // older row at c
   output logic     stage_free,
   output wb_type   wb,
   output logic     out_valid,
   input  logic     out_ready,
   output temp_type out_temp,
   output pos_type  out_row,
   output pos_type  out_col,
   output logic     out_last,
   output logic     out_done
);

   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;
   logic     phase_ff, phase_in;
   temp_type left_ff, left_in;

   logic     ov_ff, ov_in;
   temp_type ot_ff;
   pos_type  orow_ff, ocol_ff;
   logic     olast_ff, odone_ff;

   logic              out_free, retire, load_a, load_b;
   logic              row_first, row_last, col_first, col_last, border;
   logic [SUM_BITS-1:0] sum;
   temp_type          stencil;

   assign out_free  = !ov_ff || out_ready;
   assign row_first = (s1_item_ff.row == '0);
   assign row_last  = ({1'b0, s1_item_ff.row} == size_last);
   assign col_first = (s1_item_ff.col == '0);
   assign col_last  = ({1'b0, s1_item_ff.col} == size_last);
   assign border    = (s1_item_ff.row == POS_BITS'(1)) || col_first || col_last;

   assign sum = SUM_BITS'(up_rd) + SUM_BITS'(s1_item_ff.temp)
              + SUM_BITS'(left_ff) + SUM_BITS'(right_rd);
   assign stencil = border ? centre_rd : sum[SUM_BITS-1:2];

   assign load_a = s1_valid_ff && !row_first && !phase_ff && out_free;
   assign load_b = s1_valid_ff && phase_ff && out_free;
   assign retire = s1_valid_ff && (row_first || (out_free && (!row_last || phase_ff)));

   assign stage_free = !s1_valid_ff || retire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      phase_in    = phase_ff;
      left_in     = left_ff;
      ov_in       = ov_ff && !out_ready;
      if (retire) begin
         s1_valid_in = 1'b0;
         phase_in    = 1'b0;
         left_in     = col_last ? '0 : centre_rd;
      end else if (load_a && row_last) begin
         phase_in = 1'b1;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
      if (load_a || load_b) begin
         ov_in = 1'b1;
      end
      if (restart) begin
         left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
         left_ff     <= '0;
         ov_ff       <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         ov_ff       <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item;
      end
      if (load_a) begin
         ot_ff    <= stencil;
         orow_ff  <= s1_item_ff.row - POS_BITS'(1);
         ocol_ff  <= s1_item_ff.col;
         olast_ff <= !row_last;
         odone_ff <= 1'b0;
      end else if (load_b) begin
         ot_ff    <= s1_item_ff.temp;
         orow_ff  <= s1_item_ff.row;
         ocol_ff  <= s1_item_ff.col;
         olast_ff <= 1'b1;
         odone_ff <= col_last;
      end
   end

   // retire writes the arriving cell into prev and the old prev into older
   assign wb.en        = retire;
   assign wb.addr      = ADDR_BITS'(s1_item_ff.col);
   assign wb.prev_val  = s1_item_ff.temp;
   assign wb.older_val = centre_rd;

   assign out_valid = ov_ff;
   assign out_temp  = ot_ff;
   assign out_row   = orow_ff;
   assign out_col   = ocol_ff;
   assign out_last  = olast_ff;
   assign out_done  = odone_ff;

endmodule

### rtl/heat_diffusion_stencil_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_sweep
// One Jacobi sweep of a square Q8.8 grid streamed in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* takes one grid cell per item, row-major, N x N cells per frame.
//  - rsp_* returns updated cells: cell (r-1,c) once cell (r,c) has arrived,
//    borders unchanged, interior cells (up+down+left+right)>>2 truncated.
//    On the last row each item gives two results: cell (N-2,c), then the
//    arriving cell (N-1,c) itself. rsp_tlast marks the last result of an
//    input item, rsp_tuser marks cell (N-1,N-1).
//  - Row 0 items give no result.
//  - Throughput: one item per clock while rsp_tready is high, except
//    last-row items, as the result register moves one result per clock.
//  - Order: an accepted item's line buffers are read and the item is
//    registered at the accepting edge, then the result register is loaded
//    and rsp_tvalid rises; a last-row item's second result follows the first.
//  - Line buffers: previous row held twice (reads at c and c+1 in one
//    cycle), older row once; all written when the item leaves the stage.
//  - Reset: grid size 200, positions zero; buffer contents undefined.
//  - csr_we loads the grid size (clamped to 3..256) and restarts the frame;
//    write it only while the block is idle.
//  - A stalled rsp_tready holds the result register; the core stage then
//    holds an item outside row 0 and req_tready drops until room frees up.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_sweep import hds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,     // grid_size
   // input cells
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [15:0] cell_temperature
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [15:0] new_temperature,
                                      // [23:16] cell_row, [31:24] cell_column
   output logic        rsp_tlast,     // last_in_run
   output logic [0:0]  rsp_tuser      // frame_done
);

   size_type size_ff, size_in;
   pos_type  row_ff, row_in;
   pos_type  col_ff, col_in;

   size_type size_last;
   logic     accept, stage_free, col_end, row_end;
   item_type item;
   wb_type   wb;
   temp_type centre_rd, right_rd, up_rd;
   temp_type out_temp;
   pos_type  out_row, out_col;
   logic     out_done;

   assign size_last  = size_ff - SIZE_BITS'(1);
   assign req_tready = stage_free;
   assign accept     = req_tvalid && stage_free;

   assign col_end = ({1'b0, col_ff} == size_last);
   assign row_end = ({1'b0, row_ff} == size_last);

   assign item.temp = req_tdata;
   assign item.row  = row_ff;
   assign item.col  = col_ff;

   // position of the next cell to arrive
   always_comb begin
      size_in = size_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (csr_we) begin
         size_in = clamp_size(csr_wdata);
         row_in  = '0;
         col_in  = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + POS_BITS'(1);
         end else begin
            col_in = col_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= GRID_RESET;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         size_ff <= size_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   // previous row, copy read at the cell's own column
   hds_ram #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(TEMP_BITS)) u_prev_centre (
      .clock   (clock),
      .wr_en   (wb.en),
      .wr_addr (wb.addr),
      .wr_data (wb.prev_val),
      .rd_en   (accept),
      .rd_addr (ADDR_BITS'(col_ff)),
      .rd_data (centre_rd)
   );

   // previous row, copy read one column to the right
   hds_ram #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(TEMP_BITS)) u_prev_right (
      .clock   (clock),
      .wr_en   (wb.en),
      .wr_addr (wb.addr),
      .wr_data (wb.prev_val),
      .rd_en   (accept),
      .rd_addr (ADDR_BITS'(col_ff + POS_BITS'(1))),
      .rd_data (right_rd)
   );

   // row two above the arriving cell
   hds_ram #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(TEMP_BITS)) u_older (
      .clock   (clock),
      .wr_en   (wb.en),
      .wr_addr (wb.addr),
      .wr_data (wb.older_val),
      .rd_en   (accept),
      .rd_addr (ADDR_BITS'(col_ff)),
      .rd_data (up_rd)
   );

   hds_core u_core (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .size_last  (size_last),
      .accept     (accept),
      .item       (item),
      .centre_rd  (centre_rd),
      .right_rd   (right_rd),
      .up_rd      (up_rd),
      .stage_free (stage_free),
      .wb         (wb),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_temp   (out_temp),
      .out_row    (out_row),
      .out_col    (out_col),
      .out_last   (rsp_tlast),
      .out_done   (out_done)
   );

   assign rsp_tdata    = {out_col, out_row, out_temp};
   assign rsp_tuser[0] = out_done;

endmodule
